@@ rtl/obef_pkg.sv @@
// Shared types, constants and register codes for the oriented box extent fit.
package obef_pkg;

  // Stream index wraps at MAX_POINTS.
  localparam int MAX_POINTS  = 65536;
  localparam int IDX_W       = $clog2(MAX_POINTS);

  localparam int COORD_W     = 32;
  localparam int AXC_W       = 16;
  localparam int VAL_W       = 40;
  localparam int EXT_W       = 39;
  localparam int OIDX_W      = 16;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int PADDR_W     = 5;
  localparam int PDATA_W     = 32;

  // Cycles the axis derivation needs after reset or a register write.
  localparam int SETTLE_CYC  = 2;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  // Axis rows: principal (corrected), side, fixed. Columns: x, y, z.
  localparam int AX_M = 0;
  localparam int AX_C = 1;
  localparam int AX_A = 2;

  typedef logic signed [AXC_W-1:0] q15_t;
  typedef logic [2:0][2:0][AXC_W-1:0] axes_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic                      last_point;
  } point_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] center_x;
    logic signed [VAL_W-1:0] center_y;
    logic signed [VAL_W-1:0] center_z;
    logic [EXT_W-1:0]        extent_principal;
    logic [EXT_W-1:0]        extent_side;
    logic [EXT_W-1:0]        extent_fixed;
    logic [OIDX_W-1:0]       principal_min_index;
    logic [OIDX_W-1:0]       principal_max_index;
    logic [OIDX_W-1:0]       side_min_index;
    logic [OIDX_W-1:0]       side_max_index;
    logic [OIDX_W-1:0]       fixed_min_index;
    logic [OIDX_W-1:0]       fixed_max_index;
  } box_t;

  // Queue entry: a point stamped with its stream index.
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      last;
    logic [IDX_W-1:0]          idx;
  } qent_t;

  typedef struct packed {
    logic  push;
    qent_t ent;
  } q_wr_t;

  typedef struct packed {
    logic  valid;
    logic  full;
    qent_t head;
  } q_stat_t;

  typedef enum logic [2:0] {
    REG_AXIS_X = 3'd0,
    REG_AXIS_Y = 3'd1,
    REG_AXIS_Z = 3'd2,
    REG_DIR_X  = 3'd3,
    REG_DIR_Y  = 3'd4,
    REG_DIR_Z  = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    BK_RUN,
    BK_MID,
    BK_MUL,
    BK_SUM
  } bk_state_t;

endpackage

@@ rtl/obef_cfg.sv @@
// Register file and derivation of the side and corrected principal axes.
module obef_cfg import obef_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output axes_t              axes,
  output logic               settle
);

  logic [2:0][AXC_W-1:0] a_reg;
  logic [2:0][AXC_W-1:0] p_reg;
  logic [2:0][AXC_W-1:0] c_reg;
  logic [2:0][AXC_W-1:0] m_reg;
  logic [1:0]            settle_cnt;
  logic                  wr;
  logic [AXC_W-1:0]      rd_val;

  // x1*y1 - x2*y2, exact
  function automatic logic signed [2*AXC_W:0] dif(input q15_t x1, input q15_t y1,
                                                  input q15_t x2, input q15_t y2);
    logic signed [2*AXC_W-1:0] p1;
    logic signed [2*AXC_W-1:0] p2;
    p1 = x1 * y1;
    p2 = x2 * y2;
    return {p1[2*AXC_W-1], p1} - {p2[2*AXC_W-1], p2};
  endfunction

  // round half up to Q1.15 and saturate
  function automatic logic [AXC_W-1:0] rq15(input logic signed [2*AXC_W:0] v);
    logic signed [2*AXC_W+1:0] t;
    logic signed [AXC_W+2:0]   r;
    t = {v[2*AXC_W], v} + (2*AXC_W+2)'(16384);
    r = t[2*AXC_W+1:AXC_W-1];
    if (r > $signed((AXC_W+3)'(32767))) begin
      return {1'b0, {(AXC_W-1){1'b1}}};
    end else if (r < -$signed((AXC_W+3)'(32768))) begin
      return {1'b1, {(AXC_W-1){1'b0}}};
    end else begin
      return r[AXC_W-1:0];
    end
  endfunction

  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_reg <= {16'sd32767, 16'sd0, 16'sd0};
      p_reg <= {16'sd0, 16'sd0, 16'sd32767};
    end else if (wr) begin
      unique case (paddr[PADDR_W-1:2])
        REG_AXIS_X: a_reg[0] <= pwdata[AXC_W-1:0];
        REG_AXIS_Y: a_reg[1] <= pwdata[AXC_W-1:0];
        REG_AXIS_Z: a_reg[2] <= pwdata[AXC_W-1:0];
        REG_DIR_X:  p_reg[0] <= pwdata[AXC_W-1:0];
        REG_DIR_Y:  p_reg[1] <= pwdata[AXC_W-1:0];
        REG_DIR_Z:  p_reg[2] <= pwdata[AXC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[PADDR_W-1:2])
      REG_AXIS_X: rd_val = a_reg[0];
      REG_AXIS_Y: rd_val = a_reg[1];
      REG_AXIS_Z: rd_val = a_reg[2];
      REG_DIR_X:  rd_val = p_reg[0];
      REG_DIR_Y:  rd_val = p_reg[1];
      REG_DIR_Z:  rd_val = p_reg[2];
      default:    rd_val = '0;
    endcase
    prdata = {{(PDATA_W-AXC_W){rd_val[AXC_W-1]}}, rd_val};
  end

  // c = a x p, then m = -(a x c) from the rounded c
  always_ff @(posedge clk) begin
    c_reg[0] <= rq15(dif(a_reg[1], p_reg[2], a_reg[2], p_reg[1]));
    c_reg[1] <= rq15(dif(a_reg[2], p_reg[0], a_reg[0], p_reg[2]));
    c_reg[2] <= rq15(dif(a_reg[0], p_reg[1], a_reg[1], p_reg[0]));
    m_reg[0] <= rq15(dif(a_reg[2], c_reg[1], a_reg[1], c_reg[2]));
    m_reg[1] <= rq15(dif(a_reg[0], c_reg[2], a_reg[2], c_reg[0]));
    m_reg[2] <= rq15(dif(a_reg[1], c_reg[0], a_reg[0], c_reg[1]));
  end

  always_ff @(posedge clk) begin
    if (rst || wr) begin
      settle_cnt <= 2'(SETTLE_CYC);
    end else if (settle_cnt != '0) begin
      settle_cnt <= settle_cnt - 2'd1;
    end
  end

  assign settle     = (settle_cnt != '0);
  assign axes[AX_M] = m_reg;
  assign axes[AX_C] = c_reg;
  assign axes[AX_A] = a_reg;

endmodule

@@ rtl/obef_front.sv @@
// Front end: takes point requests, stamps the stream index, pushes the queue.
module obef_front import obef_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  point_t point,
  input  logic   point_valid,
  output logic   point_stall,
  input  logic   settle,
  input  logic   q_full,
  output q_wr_t  q_wr
);

  logic [IDX_W-1:0] idx;

  assign point_stall = q_full || settle;

  always_comb begin
    q_wr.push     = point_valid && !point_stall;
    q_wr.ent.x    = point.point_x;
    q_wr.ent.y    = point.point_y;
    q_wr.ent.z    = point.point_z;
    q_wr.ent.last = point.last_point;
    q_wr.ent.idx  = idx;
  end

  // index restarts after the last point of a cluster and wraps at MAX_POINTS
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (q_wr.push) begin
      if (point.last_point || idx == IDX_W'(MAX_POINTS - 1)) begin
        idx <= '0;
      end else begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

endmodule

@@ rtl/obef_queue.sv @@
// Short queue of stamped points between front and back.
module obef_queue import obef_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  q_wr_t   q_wr,
  input  logic    pop,
  output q_stat_t q_stat
);

  qent_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      mem[wr_ptr] <= q_wr.ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (q_wr.push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (q_wr.push && !pop) begin
        count <= count + (QPTR_W+1)'(1);
      end else if (pop && !q_wr.push) begin
        count <= count - (QPTR_W+1)'(1);
      end
    end
  end

  always_comb begin
    q_stat.valid = (count != '0);
    q_stat.full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
    q_stat.head  = mem[rd_ptr];
  end

endmodule

@@ rtl/obef_back.sv @@
// Back end: projection pipeline, extreme tracking and box finish sequence.
module obef_back import obef_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  axes_t   axes,
  input  q_stat_t q_stat,
  output logic    q_pop,
  output box_t    box,
  output logic    box_valid,
  input  logic    box_stall
);

  localparam int PROD_W = COORD_W + AXC_W;
  localparam int PSUM_W = PROD_W + 3;
  localparam int CPRD_W = VAL_W + AXC_W;
  localparam int CSUM_W = CPRD_W + 2;
  localparam int CRND_W = CSUM_W - 15;

  localparam logic signed [VAL_W:0] EXT_LIM =
    {{(VAL_W-EXT_W+2){1'b0}}, {(EXT_W-1){1'b1}}};
  localparam logic [EXT_W-1:0] EXT_MAX = {1'b0, {(EXT_W-1){1'b1}}};

  bk_state_t state, state_next;
  logic      out_free;
  logic      clr;
  logic      do_mid;
  logic      do_mul;

  logic signed [COORD_W-1:0] pt [3];

  logic                     s1_valid;
  logic                     s1_last;
  logic [IDX_W-1:0]         s1_idx;
  logic signed [PROD_W-1:0] s1_prod [3][3];

  logic signed [PSUM_W-1:0] psum [3];
  logic                     s2_valid;
  logic                     s2_last;
  logic [IDX_W-1:0]         s2_idx;
  logic signed [VAL_W-1:0]  s2_proj [3];

  logic signed [VAL_W-1:0]  ext_val [6];
  logic [IDX_W-1:0]         ext_idx [6];

  logic signed [VAL_W:0]    msum [3];
  logic signed [VAL_W:0]    mdiff [3];
  logic signed [VAL_W-1:0]  mid [3];
  logic [EXT_W-1:0]         ext_len [3];

  logic signed [CPRD_W-1:0] cprod [3][3];
  logic signed [CSUM_W-1:0] csum [3];
  logic signed [CRND_W-1:0] crnd [3];
  logic signed [VAL_W-1:0]  center [3];

  // ---------------- control ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_RUN;
    end else begin
      state <= state_next;
    end
  end

  assign out_free = !box_valid || !box_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      BK_RUN: if (s2_valid && s2_last) state_next = BK_MID;
      BK_MID: state_next = BK_MUL;
      BK_MUL: state_next = BK_SUM;
      BK_SUM: if (out_free) state_next = BK_RUN;
      default: state_next = BK_RUN;
    endcase
  end

  // no new point enters behind a last point until its box is out
  always_comb begin
    q_pop  = (state == BK_RUN) && q_stat.valid && !(s1_valid && s1_last) &&
             !(s2_valid && s2_last);
    do_mid = (state == BK_MID);
    do_mul = (state == BK_MUL);
    clr    = (state == BK_SUM) && out_free;
  end

  // ---------------- stage 1: products ----------------
  always_comb begin
    pt[0] = q_stat.head.x;
    pt[1] = q_stat.head.y;
    pt[2] = q_stat.head.z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= q_pop;
    end
    if (q_pop) begin
      s1_last <= q_stat.head.last;
      s1_idx  <= q_stat.head.idx;
      for (int d = 0; d < 3; d++) begin
        for (int j = 0; j < 3; j++) begin
          s1_prod[d][j] <= pt[j] * $signed(axes[d][j]);
        end
      end
    end
  end

  // ---------------- stage 2: sum and round ----------------
  // Rounded projection spans at most 34 bits, so the 40-bit limit never binds.
  always_comb begin
    for (int d = 0; d < 3; d++) begin
      psum[d] = s1_prod[d][0] + s1_prod[d][1] + s1_prod[d][2] + PSUM_W'(16384);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    if (s1_valid) begin
      s2_last <= s1_last;
      s2_idx  <= s1_idx;
      for (int d = 0; d < 3; d++) begin
        s2_proj[d] <= VAL_W'(psum[d] >>> 15);
      end
    end
  end

  // ---------------- stage 3: extremes ----------------
  // strict compares keep the earliest point on ties
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      for (int d = 0; d < 3; d++) begin
        ext_val[2*d]     <= VAL_MAX;
        ext_val[2*d + 1] <= VAL_MIN;
        ext_idx[2*d]     <= '0;
        ext_idx[2*d + 1] <= '0;
      end
    end else if (s2_valid) begin
      for (int d = 0; d < 3; d++) begin
        if (s2_proj[d] < ext_val[2*d]) begin
          ext_val[2*d] <= s2_proj[d];
          ext_idx[2*d] <= s2_idx;
        end
        if (s2_proj[d] > ext_val[2*d + 1]) begin
          ext_val[2*d + 1] <= s2_proj[d];
          ext_idx[2*d + 1] <= s2_idx;
        end
      end
    end
  end

  // ---------------- finish: midpoints and extents ----------------
  always_comb begin
    for (int d = 0; d < 3; d++) begin
      msum[d]  = ext_val[2*d + 1] + ext_val[2*d];
      mdiff[d] = ext_val[2*d + 1] - ext_val[2*d];
    end
  end

  always_ff @(posedge clk) begin
    if (do_mid) begin
      for (int d = 0; d < 3; d++) begin
        mid[d] <= msum[d][VAL_W:1];
        if (mdiff[d] < 0) begin
          ext_len[d] <= '0;
        end else if (mdiff[d] > EXT_LIM) begin
          ext_len[d] <= EXT_MAX;
        end else begin
          ext_len[d] <= mdiff[d][EXT_W-1:0];
        end
      end
    end
  end

  // ---------------- finish: center products ----------------
  always_ff @(posedge clk) begin
    if (do_mul) begin
      for (int d = 0; d < 3; d++) begin
        for (int k = 0; k < 3; k++) begin
          cprod[d][k] <= mid[d] * $signed(axes[d][k]);
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      csum[k] = cprod[AX_M][k] + cprod[AX_C][k] + cprod[AX_A][k] + CSUM_W'(16384);
      crnd[k] = csum[k][CSUM_W-1:15];
      if (crnd[k] > VAL_MAX) begin
        center[k] = VAL_MAX;
      end else if (crnd[k] < VAL_MIN) begin
        center[k] = VAL_MIN;
      end else begin
        center[k] = crnd[k][VAL_W-1:0];
      end
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      box_valid <= 1'b0;
    end else if (clr) begin
      box_valid <= 1'b1;
    end else if (!box_stall) begin
      box_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clr) begin
      box.center_x            <= center[0];
      box.center_y            <= center[1];
      box.center_z            <= center[2];
      box.extent_principal    <= ext_len[AX_M];
      box.extent_side         <= ext_len[AX_C];
      box.extent_fixed        <= ext_len[AX_A];
      box.principal_min_index <= OIDX_W'(ext_idx[0]);
      box.principal_max_index <= OIDX_W'(ext_idx[1]);
      box.side_min_index      <= OIDX_W'(ext_idx[2]);
      box.side_max_index      <= OIDX_W'(ext_idx[3]);
      box.fixed_min_index     <= OIDX_W'(ext_idx[4]);
      box.fixed_max_index     <= OIDX_W'(ext_idx[5]);
    end
  end

endmodule

@@ rtl/oriented_box_extent_fit.sv @@
// Throughput: one point request per cycle while the queue has room and the axes are settled;
//   after a last point the back takes no point until its box is out, also waiting while a box is stalled.
// Finish path: a last point passes through queue read and products, round, extreme update,
//   midpoint, center multiply and sum before box valid; the sum waits while a box is stalled.
// Rate is set by the extreme compare-update loop; the 4-entry queue absorbs most of the finish gap.
// Reset (synchronous, rst high): registers take default axes, extremes and index clear,
//   and point requests stall while the derived axes settle (also after writes).
module oriented_box_extent_fit import obef_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // point requests
  input  point_t             point,
  input  logic               point_valid,
  output logic               point_stall,
  // box results
  output box_t               box,
  output logic               box_valid,
  input  logic               box_stall,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  axes_t   axes;
  logic    settle;
  q_wr_t   q_wr;
  q_stat_t q_stat;
  logic    q_pop;

  // axis registers; side and corrected principal axes are derived here
  obef_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .axes    (axes),
    .settle  (settle)
  );

  // front: accepts points and stamps the stream index
  obef_front u_front (
    .clk         (clk),
    .rst         (rst),
    .point       (point),
    .point_valid (point_valid),
    .point_stall (point_stall),
    .settle      (settle),
    .q_full      (q_stat.full),
    .q_wr        (q_wr)
  );

  // decouples the front from the back's finish sequence
  obef_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .q_wr   (q_wr),
    .pop    (q_pop),
    .q_stat (q_stat)
  );

  // back: projections, running extremes, box center and extents
  obef_back u_back (
    .clk       (clk),
    .rst       (rst),
    .axes      (axes),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .box       (box),
    .box_valid (box_valid),
    .box_stall (box_stall)
  );

endmodule
